### rtl/brt_pkg.sv
package brt_pkg;

	localparam int VOLT_W   = 16;
	localparam int EST_W    = 24;
	localparam int VAR_W    = 18;
	localparam int GAIN_W   = 17;
	localparam int WIN_W    = 8;
	localparam int TIME_W   = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// shared divider sizes
	localparam int DSR_W  = 25;
	localparam int DVD_W  = 34;
	localparam int STEP_W = 6;

	// multiplier operand and product sizes
	localparam int MUL_A_W = 17;
	localparam int MUL_B_W = 25;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_VOLTAGE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_VOLTAGE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_FRACTION     = 3'd5;

	localparam logic [15:0] RST_PROCESS_NOISE     = 16'd1442;
	localparam logic [15:0] RST_MEASUREMENT_NOISE = 16'd40436;
	localparam logic [15:0] RST_FULL_VOLTAGE      = 16'd3226;
	localparam logic [15:0] RST_EMPTY_VOLTAGE     = 16'd2842;
	localparam logic [7:0]  RST_WINDOW_LENGTH     = 8'd5;
	localparam logic [15:0] RST_STEP_FRACTION     = 16'd6554;

	localparam logic [STEP_W-1:0] GAIN_STEPS = 6'd17;
	localparam logic [STEP_W-1:0] TIME_STEPS = 6'd34;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
		logic [DSR_W-1:0]  rem;
		logic [DVD_W-1:0]  dvd;
		logic [DSR_W-1:0]  dsr;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quo;
	} div_rsp_t;

endpackage

### rtl/kalman_battery_runtime_estimator.sv
// Battery runtime estimator with a scalar Kalman filter per channel.
// Input stream: s_tdata carries the voltage sample (Q8.8), s_tuser the channel.
// A word is taken when s_tvalid and s_tready are high at a clock edge; s_tready
// is high only while the sequencer is idle.
// Output stream: one word per input word, filtered voltage and remaining time
// in m_tdata, channel and saturation flag in m_tuser, held until m_tready.
// Each word passes from acceptance to the output register through one
// 17-step gain division and one 34-step time division in the single
// restoring divider, plus a shared multiplier used three times, one pass each.
// A zero gain denominator skips the first division; a zero distance to full
// voltage, a zero slope, a negative projection or an early overflow skips the
// second. A new word is taken only after the result of the last one sits in
// the output register; if the receiver stalls, a finished result waits in the
// sequencer until the output register frees up.
// Configuration uses cfg_write, cfg_index and cfg_data, one register a cycle,
// and must only change while the block is idle.
// Reset clears the filter state of all channels and loads the default
// noise, voltage, window and step settings.
module kalman_battery_runtime_estimator
	import brt_pkg::*;
#(
	parameter int CHANNELS = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [15:0]           s_tdata,   // voltage_sample
	input  logic [0:0]            s_tuser,   // channel
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [39:0]           m_tdata,   // filtered_voltage, remaining_time
	output logic [1:0]            m_tuser,   // channel_out, time_saturated
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_SUM, S_KDIV, S_KWAIT, S_KMUL, S_XUPD,
		S_PUPD, S_PROJ, S_PWAIT, S_TIME, S_DONE
	} state_t;

	state_t state_q;

	logic [15:0] q_noise_q, r_noise_q, full_q, empty_q, step_q;
	logic [7:0]  win_q;

	logic [EST_W-1:0] est_q [CHANNELS];
	logic [VAR_W-1:0] var_q [CHANNELS];

	logic [CH_W-1:0]    ch_q;
	logic               chbit_q;
	logic [VOLT_W-1:0]  z_q;
	logic [EST_W-1:0]   x_q;
	logic [VAR_W-1:0]   pt_q;
	logic [VAR_W:0]     sum_q;
	logic               dneg_q;
	logic [EST_W-1:0]   mag_q;
	logic [GAIN_W-1:0]  k_q;
	logic [PROD_W-1:0]  prod_q;
	logic [DSR_W:0]     den_q;
	logic               opp_q;
	logic [VOLT_W-1:0]  fv_q;
	logic [DVD_W:0]     t_q;
	logic [TIME_W-1:0]  time_q;
	logic               sat_q;

	logic               m_tvalid_q;
	logic [39:0]        m_tdata_q;
	logic [1:0]         m_tuser_q;

	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [CH_W-1:0]   ch_sel;
	logic [WIN_W-1:0]  w;
	logic [VAR_W:0]    pt_sum;
	logic [VAR_W-1:0]  pt_sat;
	logic [EST_W:0]    diff;
	logic [PROD_W-1:0] prod_rnd;
	logic [EST_W-1:0]  adj;
	logic [EST_W-1:0]  x_new;
	logic [VAR_W-1:0]  p_new;
	logic [EST_W:0]    x_rnd;
	logic [DSR_W:0]    den;
	logic [VOLT_W:0]   dv;
	logic [VOLT_W-1:0] dv_mag;
	logic [DSR_W-1:0]  ud;
	logic [23:0]       span;
	logic              early_ovf;
	logic [DSR_W-1:0]  offs;
	logic [DVD_W:0]    t_new;
	logic [DVD_W:0]    t_rnd;

	always_comb begin
		ch_sel = (32'(s_tuser[0]) >= CHANNELS) ? LAST_CH : CH_W'(s_tuser[0]);
		w      = (win_q == '0) ? WIN_W'(1) : win_q;
		pt_sum = {1'b0, var_q[ch_q]} + {3'b0, q_noise_q};
		pt_sat = pt_sum[VAR_W] ? {VAR_W{1'b1}} : pt_sum[VAR_W-1:0];
		diff   = {1'b0, z_q, 8'b0} - {1'b0, x_q};
		prod_rnd = prod_q + PROD_W'(32768);
		adj    = prod_rnd[39:16];
		x_new  = dneg_q ? (x_q - adj) : (x_q + adj);
		p_new  = prod_rnd[33:16];
		x_rnd  = {1'b0, x_q} + (EST_W + 1)'(128);
		den    = {2'b0, full_q, 8'b0} - {2'b0, x_q};
		dv     = {1'b0, full_q} - {1'b0, empty_q};
		dv_mag = dv[VOLT_W] ? VOLT_W'(-dv) : dv[VOLT_W-1:0];
		ud     = den_q[DSR_W] ? DSR_W'(-den_q) : den_q[DSR_W-1:0];
		span   = prod_q[23:0];
		early_ovf = {11'b0, span[23:10]} >= ud;
		offs   = {1'b0, w, 16'b0} + {9'b0, step_q};
		t_new  = {1'b0, div_rsp.quo} - {10'b0, offs};
		t_rnd  = t_q + (DVD_W + 1)'(128);
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_KMUL: begin
				mul_a = k_q;
				mul_b = {1'b0, mag_q};
			end
			S_XUPD: begin
				mul_a = GAIN_W'(65536) - k_q;
				mul_b = {7'b0, pt_q};
			end
			S_PUPD: begin
				mul_a = {1'b0, dv_mag};
				mul_b = {17'b0, w};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		div_req = '0;
		case (state_q)
			S_KDIV: begin
				div_req.start = (sum_q != '0);
				div_req.steps = GAIN_STEPS;
				div_req.rem   = {8'b0, pt_q[VAR_W-1:1]};
				div_req.dvd   = {pt_q[0], 33'b0};
				div_req.dsr   = {6'b0, sum_q};
			end
			S_PROJ: begin
				div_req.start = (den_q != '0) && !opp_q && (span != '0) && !early_ovf;
				div_req.steps = TIME_STEPS;
				div_req.rem   = {11'b0, span[23:10]};
				div_req.dvd   = {span[9:0], 24'b0};
				div_req.dsr   = ud;
			end
			default: div_req = '0;
		endcase
	end

	brt_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_noise_q <= RST_PROCESS_NOISE;
			r_noise_q <= RST_MEASUREMENT_NOISE;
			full_q    <= RST_FULL_VOLTAGE;
			empty_q   <= RST_EMPTY_VOLTAGE;
			win_q     <= RST_WINDOW_LENGTH;
			step_q    <= RST_STEP_FRACTION;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_PROCESS_NOISE:     q_noise_q <= cfg_data;
				CFG_MEASUREMENT_NOISE: r_noise_q <= cfg_data;
				CFG_FULL_VOLTAGE:      full_q    <= cfg_data;
				CFG_EMPTY_VOLTAGE:     empty_q   <= cfg_data;
				CFG_WINDOW_LENGTH:     win_q     <= cfg_data[WIN_W-1:0];
				CFG_STEP_FRACTION:     step_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				est_q[i] <= '0;
				var_q[i] <= '0;
			end
		end else begin
			if (m_tvalid_q && m_tready && state_q != S_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						ch_q    <= ch_sel;
						chbit_q <= s_tuser[0];
						z_q     <= s_tdata;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					x_q     <= est_q[ch_q];
					pt_q    <= pt_sat;
					state_q <= S_SUM;
				end
				S_SUM: begin
					sum_q   <= {1'b0, pt_q} + {3'b0, r_noise_q};
					dneg_q  <= diff[EST_W];
					mag_q   <= diff[EST_W] ? EST_W'(-diff) : diff[EST_W-1:0];
					state_q <= S_KDIV;
				end
				S_KDIV: begin
					if (sum_q == '0) begin
						k_q     <= '0;
						state_q <= S_KMUL;
					end else begin
						state_q <= S_KWAIT;
					end
				end
				S_KWAIT: begin
					if (div_rsp.done) begin
						k_q     <= div_rsp.quo[GAIN_W-1:0];
						state_q <= S_KMUL;
					end
				end
				S_KMUL: begin
					state_q <= S_XUPD;
				end
				S_XUPD: begin
					x_q     <= x_new;
					state_q <= S_PUPD;
				end
				S_PUPD: begin
					est_q[ch_q] <= x_q;
					var_q[ch_q] <= p_new;
					fv_q    <= x_rnd[EST_W] ? {VOLT_W{1'b1}} : x_rnd[EST_W-1:8];
					den_q   <= den;
					opp_q   <= dv[VOLT_W] ^ den[DSR_W];
					state_q <= S_PROJ;
				end
				S_PROJ: begin
					if (den_q == '0 || (!opp_q && span != '0 && early_ovf)) begin
						time_q  <= {TIME_W{1'b1}};
						sat_q   <= 1'b1;
						state_q <= S_DONE;
					end else if (opp_q || span == '0) begin
						time_q  <= '0;
						sat_q   <= 1'b0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_PWAIT;
					end
				end
				S_PWAIT: begin
					if (div_rsp.done) begin
						t_q     <= t_new;
						state_q <= S_TIME;
					end
				end
				S_TIME: begin
					if (t_q[DVD_W]) begin
						time_q <= '0;
						sat_q  <= 1'b0;
					end else if (t_rnd[DVD_W:32] != '0) begin
						time_q <= {TIME_W{1'b1}};
						sat_q  <= 1'b1;
					end else begin
						time_q <= t_rnd[31:8];
						sat_q  <= 1'b0;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {time_q, fv_q};
						m_tuser_q  <= {sat_q, chbit_q};
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

### rtl/brt_divider.sv
module brt_divider
	import brt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DSR_W-1:0]  rem_q;
	logic [DSR_W-1:0]  dsr_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [DVD_W-1:0]  quo_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DSR_W:0]   shifted;
	logic [DSR_W+1:0] trial;
	logic             borrow;

	// one restoring step: shift in the next dividend bit, try a subtract
	always_comb begin
		shifted = {rem_q, dvd_q[DVD_W-1]};
		trial   = {1'b0, shifted} - {2'b0, dsr_q};
		borrow  = trial[DSR_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				rem_q  <= req.rem;
				dvd_q  <= req.dvd;
				dsr_q  <= req.dsr;
				quo_q  <= '0;
				cnt_q  <= req.steps;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= borrow ? shifted[DSR_W-1:0] : trial[DSR_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], ~borrow};
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule
